>>> design/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smm_pkg - shared types and constants of the square matrix multiplier
// Field widths, parameter defaults, sequencer states and the tag that
// travels with each element of C through the lanes and the adder tree.
// ============================================================================
package smm_pkg;

    // Parameter defaults
    localparam int MAX_SIZE_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // Fixed field widths
    localparam int SIZE_W      = 4;
    localparam int INDEX_W     = 3;
    localparam int RESULT_W    = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int ROUND_W     = 64;

    // Matrix size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    // Saturation bounds of the result, in the rounding width
    localparam logic signed [ROUND_W-1:0] SAT_HI =
        (ROUND_W'(64'sd1) <<< (RESULT_W - 1)) - ROUND_W'(64'sd1);
    localparam logic signed [ROUND_W-1:0] SAT_LO =
        -(ROUND_W'(64'sd1) <<< (RESULT_W - 1));

    // Sequencer states
    typedef enum logic {
        ST_LOAD,
        ST_ISSUE
    } state_t;

    // Control that travels with one element of C
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
    } tag_t;

endpackage
`default_nettype wire

>>> design/smm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smm_lane - one multiply lane of the square matrix multiplier
// Lane k holds column k of A and row k of B in two small banks and forms
// A[i][k] * B[k][j] for the element of C being issued.
// ============================================================================
module smm_lane #(
    parameter int MAX_SIZE   = smm_pkg::MAX_SIZE_DEF,
    parameter int DATA_WIDTH = smm_pkg::DATA_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               advance,
    input  wire                               a_wr_en,
    input  wire  [$clog2(MAX_SIZE)-1:0]       a_wr_addr,
    input  wire  [DATA_WIDTH-1:0]             a_wr_data,
    input  wire                               b_wr_en,
    input  wire  [$clog2(MAX_SIZE)-1:0]       b_wr_addr,
    input  wire  [DATA_WIDTH-1:0]             b_wr_data,
    input  wire  [$clog2(MAX_SIZE)-1:0]       a_rd_addr,
    input  wire  [$clog2(MAX_SIZE)-1:0]       b_rd_addr,
    input  wire                               lane_on,
    output logic signed [2*DATA_WIDTH-1:0]    product
);

    localparam int PROD_W = 2 * DATA_WIDTH;

    logic [DATA_WIDTH-1:0]    a_mem [MAX_SIZE];
    logic [DATA_WIDTH-1:0]    b_mem [MAX_SIZE];
    logic [DATA_WIDTH-1:0]    a_rd_reg;
    logic [DATA_WIDTH-1:0]    b_rd_reg;
    logic                     on_reg;
    logic signed [DATA_WIDTH-1:0] a_s;
    logic signed [DATA_WIDTH-1:0] b_s;
    logic signed [PROD_W-1:0] mul;
    logic signed [PROD_W-1:0] prod_reg;

    // Write the A bank (column k of A, addressed by row)
    always_ff @(posedge clk)
    begin
        if (a_wr_en)
        begin
            a_mem[a_wr_addr] <= a_wr_data;
        end
    end

    // Write the B bank (row k of B, addressed by column)
    always_ff @(posedge clk)
    begin
        if (b_wr_en)
        begin
            b_mem[b_wr_addr] <= b_wr_data;
        end
    end

    // Read both banks into registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_rd_reg <= a_mem[a_rd_addr];
            b_rd_reg <= b_mem[b_rd_addr];
            on_reg   <= lane_on;
        end
    end

    // Multiply the two operands
    assign a_s = a_rd_reg;
    assign b_s = b_rd_reg;
    assign mul = a_s * b_s;

    // Register the product; drop lanes beyond the matrix size
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= on_reg ? mul : '0;
        end
    end

    assign product = prod_reg;

endmodule
`default_nettype wire

>>> design/smm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smm_merge - lane merge, rounding and saturation
// Sums the lane products in a registered adder tree, adds half an LSB,
// shifts out the fraction bits and saturates to the 32-bit result.
// ============================================================================
module smm_merge #(
    parameter int MAX_SIZE   = smm_pkg::MAX_SIZE_DEF,
    parameter int DATA_WIDTH = smm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = smm_pkg::FRAC_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   advance,
    input  wire signed [2*DATA_WIDTH-1:0]         lane_prod [MAX_SIZE],
    input  wire  smm_pkg::tag_t                   tag_in,
    output logic [smm_pkg::RESULT_W-1:0]          result,
    output smm_pkg::tag_t                         tag_out
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int LEVELS = $clog2(MAX_SIZE);
    localparam int NODES  = 1 << LEVELS;
    localparam int SUM_W  = PROD_W + LEVELS;
    localparam int ACC_W  = (SUM_W > smm_pkg::ROUND_W) ? smm_pkg::ROUND_W : SUM_W;
    localparam int RND_W  = smm_pkg::ROUND_W;
    localparam logic signed [RND_W-1:0] HALF =
        (RND_W'(64'd1) << FRAC_BITS) >> 1;

    logic signed [ACC_W-1:0] leaf [NODES];
    logic signed [ACC_W-1:0] node_reg [1:LEVELS][NODES];
    smm_pkg::tag_t           lvl_tag_reg [1:LEVELS];
    logic signed [RND_W-1:0] rnd_reg;
    smm_pkg::tag_t           rnd_tag_reg;
    logic signed [RND_W-1:0] shifted;
    logic signed [RND_W-1:0] sat_next;
    logic [smm_pkg::RESULT_W-1:0] out_reg;
    smm_pkg::tag_t           out_tag_reg;

    // Widen lane products; pad the tree with zeros
    for (genvar n = 0; n < NODES; n++)
    begin : g_leaf
        if (n < MAX_SIZE)
        begin : g_used
            assign leaf[n] = ACC_W'(lane_prod[n]);
        end
        else
        begin : g_pad
            assign leaf[n] = '0;
        end
    end

    // Registered adder tree, one level per stage
    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        for (genvar n = 0; n < (NODES >> l); n++)
        begin : g_node
            if (l == 1)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        node_reg[l][n] <= leaf[2*n] + leaf[2*n+1];
                    end
                end
            end
            else
            begin : g_upper
                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        node_reg[l][n] <= node_reg[l-1][2*n] + node_reg[l-1][2*n+1];
                    end
                end
            end
        end
    end

    // Advance the tags alongside the tree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 1; l <= LEVELS; l++)
            begin
                lvl_tag_reg[l] <= '0;
            end
            rnd_tag_reg <= '0;
            out_tag_reg <= '0;
        end
        else if (advance)
        begin
            lvl_tag_reg[1] <= tag_in;
            for (int l = 2; l <= LEVELS; l++)
            begin
                lvl_tag_reg[l] <= lvl_tag_reg[l-1];
            end
            rnd_tag_reg <= lvl_tag_reg[LEVELS];
            out_tag_reg <= rnd_tag_reg;
        end
    end

    // Add half an LSB in the full rounding width
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rnd_reg <= RND_W'(node_reg[LEVELS][0]) + HALF;
        end
    end

    // Shift out the fraction and saturate
    assign shifted = rnd_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > smm_pkg::SAT_HI)
        begin
            sat_next = smm_pkg::SAT_HI;
        end
        else if (shifted < smm_pkg::SAT_LO)
        begin
            sat_next = smm_pkg::SAT_LO;
        end
        else
        begin
            sat_next = shifted;
        end
    end

    // Hold the result for the output side
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= sat_next[smm_pkg::RESULT_W-1:0];
        end
    end

    assign result  = out_reg;
    assign tag_out = out_tag_reg;

endmodule
`default_nettype wire

>>> design/square_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// square_matrix_multiply - C = A x B for square matrices up to MAX_SIZE
// Loads A and B element pairs row-major, then streams out C row-major.
// ============================================================================
// A matrix of size n (matrix_size, clamped to 1..MAX_SIZE) is loaded as n*n
// requests, one per cycle, each carrying A[r][c] and B[r][c]. Once the last
// request is in, the input side stalls while the sequencer issues one element
// of C per cycle whenever the output is not stalled: MAX_SIZE multiply lanes,
// each holding one column of A and one row of B, form all n products of an
// element at once and a registered adder tree merges them. Each element of C
// passes through the bank read, product, adder tree, rounding and output
// registers; loading of the next matrix may begin as soon as the last element
// is issued. Output backpressure stalls the whole issue pipeline. Each element
// is the exact sum of products, rounded half up, shifted right by FRAC_BITS
// and saturated to 32 bits.
// Writing matrix_size restarts loading; write it only while the block is idle.
// ============================================================================
module square_matrix_multiply #(
    parameter int MAX_SIZE   = smm_pkg::MAX_SIZE_DEF,
    parameter int DATA_WIDTH = smm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = smm_pkg::FRAC_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Configuration
    input  wire                                 matrix_size_wr_en,
    input  wire  [smm_pkg::SIZE_W-1:0]          matrix_size_wr_data,
    // Input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_element, b_element, zero pad to whole bytes
    input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // product_element[31:0], row_index[34:32], column_index[37:35], zero pad
    output logic [smm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int N_W    = $clog2(MAX_SIZE + 1);
    localparam int CMP_W  = (smm_pkg::SIZE_W > N_W) ? smm_pkg::SIZE_W : N_W;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int PAD_W  = smm_pkg::OUT_TDATA_W - smm_pkg::RESULT_W
                            - 2 * smm_pkg::INDEX_W;

    smm_pkg::state_t            state_reg;
    smm_pkg::state_t            state_next;
    logic [smm_pkg::SIZE_W-1:0] matrix_size_reg;
    logic [CMP_W-1:0]           size_ext;
    logic [N_W-1:0]             n_eff;
    logic [IDX_W-1:0]           n_last;
    logic [IDX_W-1:0]           ld_row_reg;
    logic [IDX_W-1:0]           ld_col_reg;
    logic [IDX_W-1:0]           iss_row_reg;
    logic [IDX_W-1:0]           iss_col_reg;
    logic                       in_fire;
    logic                       issue_fire;
    logic                       advance;
    logic                       ld_done;
    logic                       iss_done;
    smm_pkg::tag_t              issue_tag;
    smm_pkg::tag_t              rd_tag_reg;
    smm_pkg::tag_t              mul_tag_reg;
    smm_pkg::tag_t              out_tag;
    logic [smm_pkg::RESULT_W-1:0] result;
    logic [DATA_WIDTH-1:0]      a_in;
    logic [DATA_WIDTH-1:0]      b_in;
    logic signed [PROD_W-1:0]   lane_prod [MAX_SIZE];

    // Hold the matrix size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= smm_pkg::SIZE_RESET;
        end
        else if (matrix_size_wr_en)
        begin
            matrix_size_reg <= matrix_size_wr_data;
        end
    end

    // Clamp the size to 1..MAX_SIZE
    assign size_ext = CMP_W'(matrix_size_reg);

    always_comb
    begin
        if (size_ext == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (size_ext > CMP_W'(MAX_SIZE))
        begin
            n_eff = N_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = N_W'(size_ext);
        end
    end

    assign n_last = IDX_W'(n_eff - N_W'(1));

    // Handshakes and pipeline advance
    assign advance    = !out_tag.valid || m_axis_tready;
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign issue_fire = (state_reg == smm_pkg::ST_ISSUE) && advance;
    assign ld_done    = (ld_row_reg == n_last) && (ld_col_reg == n_last);
    assign iss_done   = (iss_row_reg == n_last) && (iss_col_reg == n_last);

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smm_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and input ready
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            smm_pkg::ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && ld_done)
                begin
                    state_next = smm_pkg::ST_ISSUE;
                end
            end
            smm_pkg::ST_ISSUE:
            begin
                if (issue_fire && iss_done)
                begin
                    state_next = smm_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = smm_pkg::ST_LOAD;
            end
        endcase
        if (matrix_size_wr_en)
        begin
            state_next = smm_pkg::ST_LOAD;
        end
    end

    // Advance the load position in row-major order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end
        else if (matrix_size_wr_en)
        begin
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end
        else if (in_fire)
        begin
            if (ld_col_reg == n_last)
            begin
                ld_col_reg <= '0;
                ld_row_reg <= (ld_row_reg == n_last) ? '0 : ld_row_reg + IDX_W'(1);
            end
            else
            begin
                ld_col_reg <= ld_col_reg + IDX_W'(1);
            end
        end
    end

    // Advance the issue position in row-major order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_row_reg <= '0;
            iss_col_reg <= '0;
        end
        else if (issue_fire)
        begin
            if (iss_col_reg == n_last)
            begin
                iss_col_reg <= '0;
                iss_row_reg <= (iss_row_reg == n_last) ? '0 : iss_row_reg + IDX_W'(1);
            end
            else
            begin
                iss_col_reg <= iss_col_reg + IDX_W'(1);
            end
        end
    end

    // Tag of the element being issued
    always_comb
    begin
        issue_tag.valid = (state_reg == smm_pkg::ST_ISSUE);
        issue_tag.last  = iss_done;
        issue_tag.row   = smm_pkg::INDEX_W'(iss_row_reg);
        issue_tag.col   = smm_pkg::INDEX_W'(iss_col_reg);
    end

    // Carry the tag through bank read and multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg  <= '0;
            mul_tag_reg <= '0;
        end
        else if (advance)
        begin
            rd_tag_reg  <= issue_tag;
            mul_tag_reg <= rd_tag_reg;
        end
    end

    assign a_in = s_axis_tdata[DATA_WIDTH-1:0];
    assign b_in = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // Multiply lanes, one per inner-product index
    for (genvar k = 0; k < MAX_SIZE; k++)
    begin : g_lane
        smm_lane #(
            .MAX_SIZE   (MAX_SIZE),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .clk        (clk),
            .advance    (advance),
            .a_wr_en    (in_fire && (ld_col_reg == IDX_W'(k))),
            .a_wr_addr  (ld_row_reg),
            .a_wr_data  (a_in),
            .b_wr_en    (in_fire && (ld_row_reg == IDX_W'(k))),
            .b_wr_addr  (ld_col_reg),
            .b_wr_data  (b_in),
            .a_rd_addr  (iss_row_reg),
            .b_rd_addr  (iss_col_reg),
            .lane_on    (N_W'(k) < n_eff),
            .product    (lane_prod[k])
        );
    end

    // Merge the lanes, round and saturate
    smm_merge #(
        .MAX_SIZE   (MAX_SIZE),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .lane_prod  (lane_prod),
        .tag_in     (mul_tag_reg),
        .result     (result),
        .tag_out    (out_tag)
    );

    // Drive the output stream
    assign m_axis_tvalid = out_tag.valid;
    assign m_axis_tlast  = out_tag.last;
    assign m_axis_tdata  = {PAD_W'(0), out_tag.col, out_tag.row, result};

endmodule
`default_nettype wire

>>> design/smm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// smm_checker - port-level checks of the square matrix multiplier
// Watches both streams for held requests and the output for frame ordering.
// ============================================================================
module smm_checker #(
    parameter int DATA_WIDTH = smm_pkg::DATA_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_axis_tvalid,
    input  wire                                 s_axis_tready,
    input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    input  wire                                 m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire  [smm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                 m_axis_tlast
);

    localparam int ROW_LO = smm_pkg::RESULT_W;
    localparam int COL_LO = smm_pkg::RESULT_W + smm_pkg::INDEX_W;

    logic [smm_pkg::INDEX_W-1:0] out_row;
    logic [smm_pkg::INDEX_W-1:0] out_col;

    assign out_row = m_axis_tdata[ROW_LO +: smm_pkg::INDEX_W];
    assign out_col = m_axis_tdata[COL_LO +: smm_pkg::INDEX_W];

    // Hold a stalled input request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input request changed while stalled");

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // The final element sits on the diagonal corner
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> out_row == out_col)
        else $error("last element is not on the diagonal");

    // A new frame starts at the top-left element
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> !m_axis_tvalid || (out_row == '0 && out_col == '0))
        else $error("frame does not start at row zero, column zero");

endmodule

bind square_matrix_multiply smm_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_smm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast)
);
`default_nettype wire
